// ===== design/ide_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ide_pkg
// Shared types and constants of the indexed deque engine.
// ----------------------------------------------------------------------------
package ide_pkg;

  localparam int Capacity  = 256;
  localparam int SlotW     = $clog2(Capacity);
  localparam int CountW    = $clog2(Capacity + 1);
  localparam int DataW     = 32;

  typedef logic [SlotW-1:0]  slot_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [DataW-1:0]  data_t;

  typedef enum logic [2:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_INSERT     = 3'd4,
    K_DELETE     = 3'd5,
    K_READ       = 3'd6,
    K_CLEAR      = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  position;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [8:0]  count;
    logic        is_empty;
  } rsp_t;

endpackage

// ===== design/ide_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ide_if
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
interface ide_req_if;
  logic valid;
  logic ready;
  ide_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ide_rsp_if;
  logic valid;
  logic ready;
  ide_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/ide_free_alloc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ide_free_alloc
// Free slot map with a lowest-free-slot finder through a registered tree.
// ----------------------------------------------------------------------------
module ide_free_alloc (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear_all,
  input  logic          take,
  input  logic          give,
  input  ide_pkg::slot_t give_slot,
  output ide_pkg::slot_t free_slot
);
  import ide_pkg::*;

  localparam int Groups = (Capacity + 15) / 16;

  logic [Capacity-1:0] used;
  logic [Groups-1:0]   grp_free;
  logic [3:0]          grp_low [Groups];
  logic [Groups-1:0]   grp_free_q;
  logic [3:0]          grp_low_q [Groups];
  slot_t               pick;

  // First level: lowest free bit inside each group of sixteen.
  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp_free[g] = 1'b0;
      grp_low[g]  = '0;
      for (int b = 15; b >= 0; b--) begin
        if (g * 16 + b < Capacity && !used[g * 16 + b]) begin
          grp_free[g] = 1'b1;
          grp_low[g]  = 4'(b);
        end
      end
    end
  end

  // Second level: lowest group with a free bit.
  always_comb begin
    pick = '0;
    for (int g = Groups - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        pick = slot_t'(g * 16 + int'(grp_low_q[g]));
      end
    end
  end

  assign free_slot = pick;

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      used <= '0;
    end else begin
      if (take) used[free_slot] <= 1'b1;
      if (give) used[give_slot] <= 1'b0;
    end
    grp_free_q <= grp_free;
    for (int g = 0; g < Groups; g++) grp_low_q[g] <= grp_low[g];
  end

endmodule

// ===== design/indexed_deque_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_deque_engine_top
// Bounded deque as a doubly linked list kept in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | kind, position, value
//  rsp     | out | status, data_out, count, is_empty
//
// One request at a time. Reads, deletes and inserts in the middle of the list
// walk the links from the front, each link read passing through the registered
// read port of the link memory (S_WALK, S_WALK_W); pops go straight to their end.
// A delete or insert in the middle of the list fixes two links instead of one.
// Errors and clear go straight from the request to the response state.
// Synchronous reset clears the control state; the free map is held in flip-flops.
// A stalled response holds the engine until it is taken.
module indexed_deque_engine_top (
  input  logic clk,
  input  logic rst,
  ide_req_if.sink   req,
  ide_rsp_if.source rsp
);
  import ide_pkg::*;

  typedef struct packed {
    data_t d;
    slot_t nx;
    slot_t pv;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC, S_WALK, S_WALK_W, S_GOT, S_LINK1, S_LINK2, S_RSP
  } state_t;

  ent_t   mem [Capacity];
  ent_t   rd_q;
  slot_t  rd_addr;
  logic   rd_en;
  logic   wr_en;
  slot_t  wr_addr;
  ent_t   wr_data;

  state_t state;
  req_t   r;
  slot_t  first_slot, last_slot, cur;
  count_t cnt;
  logic [7:0] steps;
  status_t out_status;
  data_t  out_data;
  logic   is_add, is_ins;
  slot_t  p_s, n_s;
  ent_t   cur_e;
  // second link fixup pending
  logic   fix2;
  slot_t  fix2_addr;
  logic   fix2_prev;   // 1: write pv field, 0: nx field
  slot_t  fix2_val;
  logic   fix1;
  slot_t  fix1_addr;
  logic   fix1_prev;
  slot_t  fix1_val;

  // Decoded form of the request at the port.
  state_t  dec_state;
  status_t dec_status;
  logic    dec_add, dec_ins, dec_clear;
  slot_t   dec_cur, dec_p, dec_n;
  logic [7:0] dec_pos;

  logic   al_take, al_give, al_clear;
  slot_t  al_give_slot, al_free;

  ide_free_alloc u_alloc (
    .clk(clk), .rst(rst), .clear_all(al_clear), .take(al_take),
    .give(al_give), .give_slot(al_give_slot), .free_slot(al_free)
  );

  // Link memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = (state == S_RSP);
  assign rsp.payload = '{status: out_status, data_out: out_data, count: 9'(cnt),
                         is_empty: (cnt == '0)};

  // Request decode: status, next state and link operands of a new request.
  always_comb begin
    dec_state  = S_RSP;
    dec_status = ST_OK;
    dec_add    = 1'b0;
    dec_ins    = 1'b0;
    dec_clear  = 1'b0;
    dec_cur    = first_slot;
    dec_pos    = req.payload.position;
    dec_p      = '0;
    dec_n      = '0;
    case (kind_t'(req.payload.kind))
      K_PUSH_FRONT, K_PUSH_BACK: begin
        if (cnt == count_t'(Capacity)) dec_status = ST_FULL;
        else begin
          dec_add = 1'b1; dec_state = S_ALLOC;
          dec_p = (req.payload.kind[0] && cnt != 0) ? last_slot : '0;
          dec_n = (!req.payload.kind[0] && cnt != 0) ? first_slot : '0;
          dec_pos = req.payload.kind[0] ? 8'(cnt) : '0;
        end
      end
      K_POP_FRONT, K_POP_BACK: begin
        if (cnt == 0) dec_status = ST_EMPTY;
        else begin
          dec_cur = req.payload.kind[0] ? last_slot : first_slot;
          dec_pos = req.payload.kind[0] ? 8'(cnt - 1'b1) : '0;
          dec_state = S_WALK;
        end
      end
      K_INSERT: begin
        if (count_t'(req.payload.position) > cnt) dec_status = ST_RANGE;
        else if (cnt == count_t'(Capacity)) dec_status = ST_FULL;
        else if (req.payload.position == 0 ||
                 count_t'(req.payload.position) == cnt) begin
          dec_add = 1'b1; dec_state = S_ALLOC;
          dec_p = (req.payload.position != 0) ? last_slot : '0;
          dec_n = (req.payload.position == 0 && cnt != 0) ? first_slot : '0;
        end else begin
          dec_ins = 1'b1; dec_state = S_WALK;
        end
      end
      K_DELETE, K_READ: begin
        if (count_t'(req.payload.position) >= cnt) dec_status = ST_RANGE;
        else dec_state = S_WALK;
      end
      default: begin
        dec_clear = 1'b1;
      end
    endcase
  end

  // Read-modify-write of one link field uses the last read entry.
  always_comb begin
    rd_en = 1'b0; rd_addr = cur;
    wr_en = 1'b0; wr_addr = '0; wr_data = rd_q;
    al_take = 1'b0; al_give = 1'b0; al_clear = 1'b0; al_give_slot = cur;
    case (state)
      S_WALK: begin rd_en = 1'b1; end
      S_LINK1: begin
        if (fix1) begin rd_en = 1'b1; rd_addr = fix1_addr; end
      end
      S_LINK2: begin
        if (fix1) begin
          wr_en = 1'b1; wr_addr = fix1_addr; wr_data = rd_q;
          if (fix1_prev) wr_data.pv = fix1_val; else wr_data.nx = fix1_val;
        end
      end
      default: ;
    endcase
    if (state == S_ALLOC && is_add) begin
      al_take = 1'b1;
      wr_en = 1'b1; wr_addr = al_free;
      wr_data = '{d: data_t'(r.value), nx: n_s, pv: p_s};
    end
    // Only pops and deletes return their slot; a read leaves it in place.
    if (state == S_GOT && !is_ins && !is_add && r.kind != K_READ) begin
      al_give = 1'b1;
    end
    if (state == S_IDLE && req.valid && dec_clear) al_clear = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; first_slot <= '0; last_slot <= '0; cnt <= '0;
      fix1 <= 1'b0; fix2 <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            r <= '{kind: req.payload.kind, position: dec_pos, value: req.payload.value};
            is_add <= dec_add; is_ins <= dec_ins;
            fix1 <= 1'b0; fix2 <= 1'b0;
            out_data <= '0; out_status <= dec_status;
            cur <= dec_cur; steps <= '0;
            p_s <= dec_p; n_s <= dec_n;
            state <= dec_state;
            if (dec_clear) begin
              cnt <= '0; first_slot <= '0; last_slot <= '0;
            end
          end
        end
        S_WALK: begin
          state <= S_WALK_W;
        end
        S_WALK_W: begin
          // Pop ends jump straight to the slot; others walk links.
          if (steps == r.position || r.kind == K_POP_BACK) begin
            cur_e <= rd_q; state <= S_GOT;
          end else begin
            cur <= rd_q.nx; steps <= steps + 1'b1; state <= S_WALK;
          end
        end
        S_GOT: begin
          if (is_ins) begin
            p_s <= cur_e.pv; n_s <= cur; is_add <= 1'b1; state <= S_ALLOC;
          end else if (r.kind == K_READ) begin
            out_data <= cur_e.d; state <= S_RSP;
          end else begin
            out_data <= cur_e.d;
            cnt <= cnt - 1'b1;
            state <= S_LINK1;
            if (cnt == 1) begin
              first_slot <= '0; last_slot <= '0;
            end else if (r.position == 0) begin
              first_slot <= cur_e.nx;
              fix1 <= 1'b1; fix1_addr <= cur_e.nx; fix1_prev <= 1'b1; fix1_val <= cur_e.pv;
            end else if (count_t'(r.position) == cnt - 1'b1) begin
              last_slot <= cur_e.pv;
              fix1 <= 1'b1; fix1_addr <= cur_e.pv; fix1_prev <= 1'b0; fix1_val <= cur_e.nx;
            end else begin
              fix1 <= 1'b1; fix1_addr <= cur_e.pv; fix1_prev <= 1'b0; fix1_val <= cur_e.nx;
              fix2 <= 1'b1; fix2_addr <= cur_e.nx; fix2_prev <= 1'b1; fix2_val <= cur_e.pv;
            end
          end
        end
        S_ALLOC: begin
          cnt <= cnt + 1'b1;
          state <= S_LINK1;
          if (cnt == 0) begin
            first_slot <= al_free; last_slot <= al_free;
          end else if (!is_ins && r.position == 0) begin
            first_slot <= al_free;
            fix1 <= 1'b1; fix1_addr <= first_slot; fix1_prev <= 1'b1; fix1_val <= al_free;
          end else if (!is_ins) begin
            last_slot <= al_free;
            fix1 <= 1'b1; fix1_addr <= last_slot; fix1_prev <= 1'b0; fix1_val <= al_free;
          end else begin
            fix1 <= 1'b1; fix1_addr <= p_s; fix1_prev <= 1'b0; fix1_val <= al_free;
            fix2 <= 1'b1; fix2_addr <= n_s; fix2_prev <= 1'b1; fix2_val <= al_free;
          end
        end
        S_LINK1: begin
          state <= S_LINK2;
        end
        S_LINK2: begin
          if (fix2) begin
            fix1 <= 1'b1; fix1_addr <= fix2_addr; fix1_prev <= fix2_prev;
            fix1_val <= fix2_val; fix2 <= 1'b0; state <= S_LINK1;
          end else begin
            fix1 <= 1'b0; state <= S_RSP;
          end
        end
        S_RSP: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= count_t'(Capacity)) else $error("count above capacity");
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cnt == 0) |-> (first_slot == '0 && last_slot == '0))
    else $error("ends not cleared on empty store");
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready) else $error("second request taken");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed deque engine. A directed table and a
// fill to capacity cover the ends of the store, every operation and its
// error statuses, then random requests of weighted kinds fill, drain and
// walk the list while both sides of the handshake idle at random. Each
// response is checked against a linked-list predictor held in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import ide_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [7:0]  position;
    logic [31:0] value;
    bit          typed;
    rsp_t        want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  ide_req_if req ();
  ide_rsp_if rsp ();

  indexed_deque_engine_top dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #2 clk = ~clk;

  // Predicted list contents, front first, and responses still to come.
  logic [31:0] shadow_list[$];
  rsp_t        pending_rsp[$];
  int          mismatches = 0;
  int          send_idle_pct = 22;
  int          recv_idle_pct = 65;
  bit          stim_done = 1'b0;

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Applies one request to the shadow list and returns the response it earns.
  function automatic rsp_t apply_request(input kind_t k, input logic [7:0] p,
                                         input logic [31:0] v);
    rsp_t r;
    int   n;
    n = shadow_list.size();
    r = '0;
    r.status = ST_OK;
    case (k)
      K_PUSH_FRONT, K_PUSH_BACK: begin
        if (n >= Capacity) r.status = ST_FULL;
        else if (k == K_PUSH_FRONT) shadow_list.push_front(v);
        else shadow_list.push_back(v);
      end
      K_POP_FRONT, K_POP_BACK: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (k == K_POP_FRONT) r.data_out = shadow_list.pop_front();
        else r.data_out = shadow_list.pop_back();
      end
      K_INSERT: begin
        if (p > n) r.status = ST_RANGE;
        else if (n >= Capacity) r.status = ST_FULL;
        else shadow_list.insert(p, v);
      end
      K_DELETE: begin
        if (p >= n) r.status = ST_RANGE;
        else begin
          r.data_out = shadow_list[p];
          shadow_list.delete(p);
        end
      end
      K_READ: begin
        if (p >= n) r.status = ST_RANGE;
        else r.data_out = shadow_list[p];
      end
      default: shadow_list.delete();
    endcase
    r.count = 9'(shadow_list.size());
    r.is_empty = (shadow_list.size() == 0);
    return r;
  endfunction

  // Drives one request, waits for its acceptance and records the expectation.
  task automatic send_request(input kind_t k, input logic [7:0] p,
                              input logic [31:0] v, input bit typed,
                              input rsp_t want);
    rsp_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= '{kind: k, position: p, value: v};
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    r = apply_request(k, p, v);
    if (typed && r != want) report("directed table row", 64'(r), 64'(want));
    pending_rsp.push_back(r);
  endtask

  // Response side: random stalls and field-by-field compare.
  initial begin
    rsp_t want;
    rsp_t got;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        got = rsp.payload;
        if (pending_rsp.size() == 0) report("unexpected response", 64'(got), 64'(0));
        else begin
          want = pending_rsp.pop_front();
          if (got.status !== want.status)
            report("status", 64'(got.status), 64'(want.status));
          if (got.data_out !== want.data_out)
            report("data_out", 64'(got.data_out), 64'(want.data_out));
          if (got.count !== want.count)
            report("count", 64'(got.count), 64'(want.count));
          if (got.is_empty !== want.is_empty)
            report("is_empty", 64'(got.is_empty), 64'(want.is_empty));
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Picks a random request, mostly well formed positions, some past the end.
  task automatic random_request(input int fill_bias);
    kind_t       k;
    logic [7:0]  p;
    int          n;
    int          roll;
    n = shadow_list.size();
    roll = $urandom_range(99);
    if (roll < fill_bias) k = ($urandom_range(1)) ? K_PUSH_BACK : K_PUSH_FRONT;
    else if (roll < fill_bias + 12) k = K_INSERT;
    else if (roll < fill_bias + 30) k = K_READ;
    else if (roll < fill_bias + 42) k = K_DELETE;
    else if (roll < 99) k = ($urandom_range(1)) ? K_POP_BACK : K_POP_FRONT;
    else k = K_CLEAR;
    if ($urandom_range(9) == 0) p = 8'($urandom_range(255));
    else p = 8'($urandom_range(n < 255 ? n : 255));
    send_request(k, p, $urandom, 1'b0, '0);
  endtask

  // Stimulus.
  initial begin
    row_t rows[$];
    row_t rw;
    rsp_t e;
    int   phase;
    req.valid = 1'b0;
    req.payload = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    e = '{status: ST_EMPTY, data_out: 0, count: 0, is_empty: 1};
    rows.push_back('{K_POP_FRONT, 8'd0, 32'd0, 1, e});
    rows.push_back('{K_POP_BACK, 8'd0, 32'd0, 1, e});
    e = '{status: ST_RANGE, data_out: 0, count: 0, is_empty: 1};
    rows.push_back('{K_READ, 8'd0, 32'd0, 1, e});
    rows.push_back('{K_DELETE, 8'd255, 32'd0, 1, e});
    rows.push_back('{K_INSERT, 8'd1, 32'd5, 1, e});
    e = '{status: ST_OK, data_out: 0, count: 1, is_empty: 0};
    rows.push_back('{K_INSERT, 8'd0, 32'hFFFF_FFFF, 1, e});
    rows.push_back('{K_PUSH_FRONT, 8'd0, 32'h0000_0000, 0, e});
    rows.push_back('{K_PUSH_BACK, 8'd255, 32'hA5A5_5A5A, 0, e});
    rows.push_back('{K_INSERT, 8'd3, 32'h1234_5678, 0, e});
    rows.push_back('{K_INSERT, 8'd2, 32'h5A5A_A5A5, 0, e});
    rows.push_back('{K_READ, 8'd0, 32'd0, 0, e});
    rows.push_back('{K_READ, 8'd4, 32'd0, 0, e});
    rows.push_back('{K_READ, 8'd5, 32'd0, 0, e});
    rows.push_back('{K_DELETE, 8'd2, 32'd0, 0, e});
    rows.push_back('{K_POP_BACK, 8'd0, 32'd0, 0, e});
    rows.push_back('{K_POP_FRONT, 8'd0, 32'd0, 0, e});
    e = '{status: ST_OK, data_out: 0, count: 0, is_empty: 1};
    rows.push_back('{K_CLEAR, 8'd0, 32'd0, 1, e});
    rows.push_back('{K_CLEAR, 8'd0, 32'd0, 1, e});
    foreach (rows[i]) begin
      rw = rows[i];
      send_request(rw.kind, rw.position, rw.value, rw.typed, rw.want);
    end

    // Fill to capacity, probe the full cases, then read, delete and insert at the far end and clear.
    while (shadow_list.size() < Capacity)
      send_request(K_PUSH_BACK, 8'd0, $urandom, 1'b0, '0);
    e = '{status: ST_FULL, data_out: 0, count: 256, is_empty: 0};
    send_request(K_PUSH_FRONT, 8'd0, 32'd1, 1'b1, e);
    send_request(K_PUSH_BACK, 8'd0, 32'd1, 1'b1, e);
    send_request(K_INSERT, 8'd255, 32'd1, 1'b1, e);
    send_request(K_READ, 8'd255, 32'd0, 1'b0, '0);
    send_request(K_DELETE, 8'd255, 32'd0, 1'b0, '0);
    send_request(K_INSERT, 8'd255, 32'd7, 1'b0, '0);
    send_request(K_CLEAR, 8'd0, 32'd0, 1'b0, '0);

    // Three phases of random requests with shifting idle rates and fill pressure.
    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 65;
        recv_idle_pct = 22;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (70) random_request(shadow_list.size() < 40 ? 45 : 25);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run once every response is in.
  initial begin
    wait (stim_done);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
